>>> hdl/jsu_pkg.sv
// Shared types and constants for the JSON string unescaper.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

  // Result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Error codes
  localparam logic [3:0] ERR_EXPECTED_STRING     = 4'd0;
  localparam logic [3:0] ERR_UNTERMINATED_ESCAPE = 4'd1;
  localparam logic [3:0] ERR_TRUNCATED_UNICODE   = 4'd2;
  localparam logic [3:0] ERR_INVALID_UNICODE     = 4'd3;
  localparam logic [3:0] ERR_INVALID_PAIR        = 4'd4;
  localparam logic [3:0] ERR_MISSING_PAIR        = 4'd5;
  localparam logic [3:0] ERR_UNKNOWN_ESCAPE      = 4'd6;
  localparam logic [3:0] ERR_CONTROL_CHAR        = 4'd7;
  localparam logic [3:0] ERR_UNTERMINATED_STRING = 4'd8;

  // Widest code point is 0x10FFFF
  localparam int CP_W = 21;

  // Command from the parser to the encoder
  typedef enum logic [1:0] {
    CMD_RAW,   // emit val[7:0] as is
    CMD_CP,    // emit val as UTF-8
    CMD_DONE,  // string complete
    CMD_ERR    // error, code in val[3:0]
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t           op;
    logic [CP_W-1:0]   val;
  } cmd_t;

endpackage

`default_nettype wire

>>> hdl/jsu_front.sv
// Front end: byte parser that turns each text byte into at most one command.
`timescale 1ns / 1ps
`default_nettype none

module jsu_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         take,
  input  wire logic [7:0]   in_byte,
  output jsu_pkg::cmd_t     cmd,
  output logic              cmd_valid
);
  import jsu_pkg::*;

  typedef enum logic [2:0] {
    M_WAIT,
    M_STR,
    M_ESC,
    M_HEX1,
    M_HIGH,
    M_ESC2,
    M_HEX2
  } mode_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  // Returns {valid, value} for one hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
    else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
    else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
    return r;
  endfunction

  function automatic cmd_t mk(input cmd_op_t op, input logic [CP_W-1:0] val);
    cmd_t c;
    c.op  = op;
    c.val = val;
    return c;
  endfunction

  mode_t       mode, mode_next;
  logic [15:0] hex_value, hex_next;
  logic [1:0]  digit_count, digit_count_next;
  logic        bad_digit, bad_digit_next;
  logic [9:0]  high_half, high_half_next;

  logic [4:0]      dig;
  logic [15:0]     hex_shift;
  logic            bad_now;
  logic            fourth;
  logic [CP_W-1:0] pair_cp;

  // Shared digit accumulation for both hex phases
  assign dig       = hex_digit(in_byte);
  assign hex_shift = {hex_value[11:0], dig[4] ? dig[3:0] : 4'h0};
  assign bad_now   = bad_digit | ~dig[4];
  assign fourth    = (digit_count == 2'd3);
  assign pair_cp   = 21'h10000 + {1'b0, high_half, hex_shift[9:0]};

  // Decode one byte against the current mode
  always_comb begin
    mode_next        = mode;
    hex_next         = hex_value;
    digit_count_next = digit_count;
    bad_digit_next   = bad_digit;
    high_half_next   = high_half;
    cmd_valid        = 1'b0;
    cmd              = mk(CMD_RAW, '0);
    if (take) begin
      unique case (mode)
        M_STR: begin
          cmd_valid = 1'b1;
          priority if (in_byte == CH_NUL) begin
            mode_next = M_WAIT;
            cmd       = mk(CMD_ERR, CP_W'(ERR_UNTERMINATED_STRING));
          end else if (in_byte == CH_QUOTE) begin
            mode_next = M_WAIT;
            cmd       = mk(CMD_DONE, '0);
          end else if (in_byte == CH_BSL) begin
            mode_next = M_ESC;
            cmd_valid = 1'b0;
          end else if (in_byte < CH_SPACE) begin
            mode_next = M_WAIT;
            cmd       = mk(CMD_ERR, CP_W'(ERR_CONTROL_CHAR));
          end else begin
            cmd = mk(CMD_RAW, CP_W'(in_byte));
          end
        end
        M_ESC: begin
          cmd_valid = 1'b1;
          mode_next = M_STR;
          unique case (in_byte)
            CH_NUL: begin
              mode_next = M_WAIT;
              cmd       = mk(CMD_ERR, CP_W'(ERR_UNTERMINATED_ESCAPE));
            end
            CH_QUOTE, CH_BSL, CH_SLASH: cmd = mk(CMD_RAW, CP_W'(in_byte));
            CH_B: cmd = mk(CMD_RAW, CP_W'(8'h08));
            CH_F: cmd = mk(CMD_RAW, CP_W'(8'h0C));
            CH_N: cmd = mk(CMD_RAW, CP_W'(8'h0A));
            CH_R: cmd = mk(CMD_RAW, CP_W'(8'h0D));
            CH_T: cmd = mk(CMD_RAW, CP_W'(8'h09));
            CH_U: begin
              cmd_valid        = 1'b0;
              mode_next        = M_HEX1;
              hex_next         = '0;
              digit_count_next = '0;
              bad_digit_next   = 1'b0;
            end
            default: begin
              mode_next = M_WAIT;
              cmd       = mk(CMD_ERR, CP_W'(ERR_UNKNOWN_ESCAPE));
            end
          endcase
        end
        M_HEX1, M_HEX2: begin
          if (in_byte == CH_NUL) begin
            cmd_valid = 1'b1;
            mode_next = M_WAIT;
            cmd       = mk(CMD_ERR, CP_W'(ERR_TRUNCATED_UNICODE));
          end else begin
            hex_next         = hex_shift;
            bad_digit_next   = bad_now;
            digit_count_next = fourth ? 2'd0 : digit_count + 2'd1;
            if (fourth) begin
              cmd_valid = 1'b1;
              priority if (bad_now) begin
                mode_next = M_WAIT;
                cmd       = mk(CMD_ERR, CP_W'(ERR_INVALID_UNICODE));
              end else if (mode == M_HEX1) begin
                if (hex_shift[15:10] == 6'b110110) begin
                  // High surrogate: hold its low ten bits for the pair
                  cmd_valid      = 1'b0;
                  high_half_next = hex_shift[9:0];
                  mode_next      = M_HIGH;
                end else begin
                  mode_next = M_STR;
                  cmd       = mk(CMD_CP, CP_W'(hex_shift));
                end
              end else if (hex_shift[15:10] == 6'b110111) begin
                mode_next = M_STR;
                cmd       = mk(CMD_CP, pair_cp);
              end else begin
                mode_next = M_WAIT;
                cmd       = mk(CMD_ERR, CP_W'(ERR_INVALID_PAIR));
              end
            end
          end
        end
        M_HIGH: begin
          if (in_byte == CH_BSL) begin
            mode_next = M_ESC2;
          end else begin
            cmd_valid = 1'b1;
            mode_next = M_WAIT;
            cmd       = mk(CMD_ERR, CP_W'(ERR_MISSING_PAIR));
          end
        end
        M_ESC2: begin
          if (in_byte == CH_U) begin
            mode_next        = M_HEX2;
            hex_next         = '0;
            digit_count_next = '0;
            bad_digit_next   = 1'b0;
          end else begin
            cmd_valid = 1'b1;
            mode_next = M_WAIT;
            cmd       = mk(CMD_ERR, CP_W'(ERR_MISSING_PAIR));
          end
        end
        default: begin
          // Waiting: skip whitespace, expect an opening quote
          mode_next = M_WAIT;
          if (in_byte == CH_QUOTE) begin
            mode_next = M_STR;
          end else if (!(in_byte == CH_SPACE ||
                         (in_byte >= CH_TAB && in_byte <= CH_CR))) begin
            cmd_valid = 1'b1;
            cmd       = mk(CMD_ERR, CP_W'(ERR_EXPECTED_STRING));
          end
        end
      endcase
    end
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_WAIT;
      hex_value   <= '0;
      digit_count <= '0;
      bad_digit   <= 1'b0;
      high_half   <= '0;
    end else begin
      mode        <= mode_next;
      hex_value   <= hex_next;
      digit_count <= digit_count_next;
      bad_digit   <= bad_digit_next;
      high_half   <= high_half_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/jsu_cmd_queue.sv
// Command queue between the parser and the UTF-8 encoder.
`timescale 1ns / 1ps
`default_nettype none

module jsu_cmd_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire jsu_pkg::cmd_t wdata,
  output logic               full,
  input  wire logic          pop,
  output jsu_pkg::cmd_t      rdata,
  output logic               valid
);
  import jsu_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign valid   = (count != '0);
  assign full    = (count == CW'(DEPTH));
  assign rdata   = entries[rd_ptr];

  // Store pushed words
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/jsu_back.sv
// Back end: expands commands into result words and holds the output register.
`timescale 1ns / 1ps
`default_nettype none

module jsu_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire jsu_pkg::cmd_t head,
  input  wire logic          head_valid,
  output logic               head_pop,
  input  wire logic          pop,
  output logic               empty,
  output logic [7:0]         out_byte,
  output logic [1:0]         kind,
  output logic [3:0]         error_code,
  output logic               last
);
  import jsu_pkg::*;

  logic [1:0] idx;
  logic       out_valid;
  logic [1:0] n_last;
  logic [1:0] grp;
  logic [5:0] six;
  logic       adv;

  logic [7:0] res_byte;
  logic [1:0] res_kind;
  logic [3:0] res_code;
  logic       res_last;

  // Index of the final UTF-8 byte for this code point
  always_comb begin
    priority if (head.val[20:16] != '0) n_last = 2'd3;
    else if (head.val[15:11] != '0)     n_last = 2'd2;
    else if (head.val[10:7] != '0)      n_last = 2'd1;
    else                                n_last = 2'd0;
  end

  // Pick the six-bit group for a continuation byte
  assign grp = n_last - idx;
  always_comb begin
    unique case (grp)
      2'd0:    six = head.val[5:0];
      2'd1:    six = head.val[11:6];
      2'd2:    six = head.val[17:12];
      default: six = {3'b000, head.val[20:18]};
    endcase
  end

  // Form the next result word
  always_comb begin
    res_byte = 8'h00;
    res_kind = KIND_DATA;
    res_code = 4'd0;
    res_last = 1'b1;
    unique case (head.op)
      CMD_RAW: res_byte = head.val[7:0];
      CMD_CP: begin
        res_last = (idx == n_last);
        if (idx != 2'd0) begin
          res_byte = {2'b10, six};
        end else begin
          unique case (n_last)
            2'd0:    res_byte = {1'b0, head.val[6:0]};
            2'd1:    res_byte = {3'b110, head.val[10:6]};
            2'd2:    res_byte = {4'b1110, head.val[15:12]};
            default: res_byte = {5'b11110, head.val[20:18]};
          endcase
        end
      end
      CMD_DONE: res_kind = KIND_DONE;
      default: begin
        res_kind = KIND_ERROR;
        res_code = head.val[3:0];
      end
    endcase
  end

  assign adv      = head_valid && (!out_valid || pop);
  assign head_pop = adv && res_last;
  assign empty    = !out_valid;

  // Advance the byte index and the output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= 1'b1;
        idx       <= res_last ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the output word
  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte   <= res_byte;
      kind       <= res_kind;
      error_code <= res_code;
      last       <= res_last;
    end
  end

endmodule

`default_nettype wire

>>> hdl/json_string_unescape_utf8_top.sv
// Top level of the JSON string unescaper with UTF-8 output.
//
// Input channel: a text byte is taken on a rising edge with push high and
// full low; byte 0 marks end of text. Result channel: while empty is low the
// oldest word sits on out_byte/kind/error_code/last, and pop takes it.
// Each input byte yields zero to four result words; last marks the final word
// of one input byte. A decoded \uXXXX or surrogate pair gives one to four
// UTF-8 data words, a closing quote gives a completion word, and an error
// gives one error word, after which the block waits for the next string.
// With the encoder idle, the first word of a byte is loaded at the edge after
// the one that takes the byte. Throughput: one input byte per cycle while full
// is low; the encoder emits one word per cycle while pop stays high, so a code
// point of N UTF-8 bytes occupies the encoder for N words while the parser
// keeps taking bytes into a QDEPTH-word command queue. full rises only
// when that queue is full. When pop stays low the output word holds, the
// encoder stops, and the queue then fills. Synchronous reset empties the
// queue and the output register and returns the parser to waiting for an
// opening quote. QDEPTH must be 2 or more.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_utf8_top #(
  parameter int QDEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic [1:0]      kind,
  output logic [3:0]      error_code,
  output logic            last
);
  import jsu_pkg::*;

  cmd_t cmd, head;
  logic cmd_valid, head_valid, head_pop;
  logic take;

  assign take = push && !full;

  // Parse incoming bytes
  jsu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .in_byte   (in_byte),
    .cmd       (cmd),
    .cmd_valid (cmd_valid)
  );

  // Buffer commands
  jsu_cmd_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_valid),
    .wdata (cmd),
    .full  (full),
    .pop   (head_pop),
    .rdata (head),
    .valid (head_valid)
  );

  // Encode and present results
  jsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .pop        (pop),
    .empty      (empty),
    .out_byte   (out_byte),
    .kind       (kind),
    .error_code (error_code),
    .last       (last)
  );

endmodule

`default_nettype wire

>>> hdl/jsu_checker.sv
// Port-level checks for the JSON string unescaper, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module jsu_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       full,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] out_byte,
  input wire logic [1:0] kind,
  input wire logic [3:0] error_code,
  input wire logic       last
);
  import jsu_pkg::*;

  // Reset leaves nothing to read and room to write
  a_reset_empty: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("channels not idle after reset");

  // Completion and error words always end the group of their byte
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && (kind == KIND_DONE || kind == KIND_ERROR)) |-> last)
    else $error("status word without last");

  // Only error words carry a code, and only known codes
  a_code_clean: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((kind == KIND_ERROR) ? (error_code <= ERR_UNTERMINATED_STRING)
                                     : (error_code == 4'd0)))
    else $error("bad error_code");

  // Status words carry a zero byte and kind stays in range
  a_status_byte: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind != KIND_DATA) |-> (out_byte == 8'h00 && kind != 2'd3))
    else $error("bad status word");

  // A stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(kind) &&
                          $stable(error_code) && $stable(last)))
    else $error("result changed while stalled");

endmodule

bind json_string_unescape_utf8_top jsu_checker u_jsu_checker (
  .clk        (clk),
  .rst        (rst),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .out_byte   (out_byte),
  .kind       (kind),
  .error_code (error_code),
  .last       (last)
);

`default_nettype wire

>>> bench/jsu_utf8_checker.sv
// Checker for the JSON unescaper: decodes each accepted byte and compares the words that come out.
`timescale 1ns / 1ps

module jsu_utf8_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] in_byte,
  input  logic       empty,
  input  logic       pop,
  input  logic [7:0] out_byte,
  input  logic [1:0] kind,
  input  logic [3:0] error_code,
  input  logic       last,
  output int         fail_count,
  output int         pending
);
  import jsu_pkg::*;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  typedef enum logic [2:0] {
    SCAN_WAIT,
    SCAN_STR,
    SCAN_ESC,
    SCAN_HEX1,
    SCAN_PAIR_BS,
    SCAN_PAIR_U,
    SCAN_HEX2
  } scan_state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [3:0] code;
    logic       last;
  } utf8_word_t;

  utf8_word_t  expected_words[$];
  scan_state_t scan_mode;
  logic [15:0] hex_acc;
  logic [1:0]  digits_seen;
  logic        digit_bad;
  logic [9:0]  hi_bits;
  int          step_count;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  function automatic logic [4:0] hex_digit_value(input logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return {1'b0, 4'(b - 8'h30)};
    if (b >= 8'h61 && b <= 8'h66) return {1'b0, 4'(b - 8'h61 + 8'd10)};
    if (b >= 8'h41 && b <= 8'h46) return {1'b0, 4'(b - 8'h41 + 8'd10)};
    return 5'h10;
  endfunction

  task automatic put_word(input logic [7:0] b, input logic [1:0] k, input logic [3:0] code);
    utf8_word_t w;
    w.out_byte = b;
    w.kind = k;
    w.code = code;
    w.last = 1'b0;
    expected_words.push_back(w);
    step_count++;
  endtask

  task automatic put_error(input logic [3:0] code);
    scan_mode = SCAN_WAIT;
    put_word(8'h00, KIND_ERROR, code);
  endtask

  task automatic put_escaped(input logic [7:0] b);
    scan_mode = SCAN_STR;
    put_word(b, KIND_DATA, 4'd0);
  endtask

  // Split a code point into its UTF-8 bytes
  task automatic put_utf8(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      put_word(cp[7:0], KIND_DATA, 4'd0);
    end else if (cp <= 21'h7FF) begin
      put_word({3'b110, cp[10:6]}, KIND_DATA, 4'd0);
      put_word({2'b10, cp[5:0]}, KIND_DATA, 4'd0);
    end else if (cp <= 21'hFFFF) begin
      put_word({4'b1110, cp[15:12]}, KIND_DATA, 4'd0);
      put_word({2'b10, cp[11:6]}, KIND_DATA, 4'd0);
      put_word({2'b10, cp[5:0]}, KIND_DATA, 4'd0);
    end else begin
      put_word({5'b11110, cp[20:18]}, KIND_DATA, 4'd0);
      put_word({2'b10, cp[17:12]}, KIND_DATA, 4'd0);
      put_word({2'b10, cp[11:6]}, KIND_DATA, 4'd0);
      put_word({2'b10, cp[5:0]}, KIND_DATA, 4'd0);
    end
  endtask

  task automatic start_hex(input scan_state_t next_mode);
    scan_mode = next_mode;
    hex_acc = 16'h0000;
    digits_seen = 2'd0;
    digit_bad = 1'b0;
  endtask

  // Shift in one digit; a bad digit counts as zero and is flagged
  task automatic take_nibble(input logic [7:0] b, output logic done);
    logic [4:0] d;
    d = hex_digit_value(b);
    if (d[4]) begin
      digit_bad = 1'b1;
      d = 5'd0;
    end
    hex_acc = {hex_acc[11:0], d[3:0]};
    if (digits_seen == 2'd3) begin
      digits_seen = 2'd0;
      done = 1'b1;
    end else begin
      digits_seen = digits_seen + 2'd1;
      done = 1'b0;
    end
  endtask

  // Advance the decoder by one byte and queue the words it produces
  task automatic decode_byte(input logic [7:0] b);
    logic       done;
    utf8_word_t w;
    step_count = 0;
    case (scan_mode)
      SCAN_STR: begin
        if (b == 8'h00) put_error(ERR_UNTERMINATED_STRING);
        else if (b == CH_QUOTE) begin
          scan_mode = SCAN_WAIT;
          put_word(8'h00, KIND_DONE, 4'd0);
        end else if (b == CH_BSLASH) scan_mode = SCAN_ESC;
        else if (b < 8'h20) put_error(ERR_CONTROL_CHAR);
        else put_word(b, KIND_DATA, 4'd0);
      end
      SCAN_ESC: begin
        case (b)
          8'h00: put_error(ERR_UNTERMINATED_ESCAPE);
          CH_QUOTE, CH_BSLASH, CH_SLASH: put_escaped(b);
          CH_B: put_escaped(8'h08);
          CH_F: put_escaped(8'h0C);
          CH_N: put_escaped(8'h0A);
          CH_R: put_escaped(8'h0D);
          CH_T: put_escaped(8'h09);
          CH_U: start_hex(SCAN_HEX1);
          default: put_error(ERR_UNKNOWN_ESCAPE);
        endcase
      end
      SCAN_HEX1: begin
        if (b == 8'h00) put_error(ERR_TRUNCATED_UNICODE);
        else begin
          take_nibble(b, done);
          if (done) begin
            if (digit_bad) put_error(ERR_INVALID_UNICODE);
            else if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
              hi_bits = hex_acc[9:0];
              scan_mode = SCAN_PAIR_BS;
            end else begin
              scan_mode = SCAN_STR;
              put_utf8({5'd0, hex_acc});
            end
          end
        end
      end
      SCAN_PAIR_BS: begin
        if (b == CH_BSLASH) scan_mode = SCAN_PAIR_U;
        else put_error(ERR_MISSING_PAIR);
      end
      SCAN_PAIR_U: begin
        if (b == CH_U) start_hex(SCAN_HEX2);
        else put_error(ERR_MISSING_PAIR);
      end
      SCAN_HEX2: begin
        if (b == 8'h00) put_error(ERR_TRUNCATED_UNICODE);
        else begin
          take_nibble(b, done);
          if (done) begin
            if (digit_bad) put_error(ERR_INVALID_UNICODE);
            else if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) begin
              scan_mode = SCAN_STR;
              put_utf8(21'h10000 + {1'b0, hi_bits, hex_acc[9:0]});
            end else put_error(ERR_INVALID_PAIR);
          end
        end
      end
      default: begin
        // Skip whitespace, then demand an opening quote
        scan_mode = SCAN_WAIT;
        if (b == 8'h20 || (b >= 8'h09 && b <= 8'h0D)) begin
        end else if (b == CH_QUOTE) scan_mode = SCAN_STR;
        else put_error(ERR_EXPECTED_STRING);
      end
    endcase
    // Mark the final word of this byte
    if (step_count > 0) begin
      w = expected_words.pop_back();
      w.last = 1'b1;
      expected_words.push_back(w);
    end
  endtask

  task automatic check_word();
    utf8_word_t want;
    if (expected_words.size() == 0) begin
      report_mismatch($sformatf("unexpected word out_byte=%02h kind=%0d code=%0d last=%0d",
                                out_byte, kind, error_code, last));
    end else begin
      want = expected_words.pop_front();
      if (out_byte !== want.out_byte)
        report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want.out_byte));
      if (kind !== want.kind)
        report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
      if (error_code !== want.code)
        report_mismatch($sformatf("error_code %0d, want %0d", error_code, want.code));
      if (last !== want.last)
        report_mismatch($sformatf("last %0d, want %0d", last, want.last));
    end
  endtask

  // Sample both channels on each rising edge
  always @(posedge clk) begin
    if (rst) begin
      expected_words.delete();
      scan_mode = SCAN_WAIT;
      hex_acc = 16'h0000;
      digits_seen = 2'd0;
      digit_bad = 1'b0;
      hi_bits = 10'd0;
      fail_count = 0;
      pending <= 0;
    end else begin
      if (push && !full) decode_byte(in_byte);
      if (pop && !empty) check_word();
      pending <= expected_words.size();
    end
  end

endmodule

>>> bench/json_string_unescape_utf8_top_tb.sv
// Testbench top for the JSON unescaper: drives text bytes, pops words and reports the verdict.
`timescale 1ns / 1ps

module json_string_unescape_utf8_top_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_BYTES    = 75;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       pop = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic [3:0] error_code;
  logic       last;
  int         fail_count;
  int         pending;

  int send_level = 0;
  int pop_level = 0;
  int pop_wait = 0;
  int idle_run = 0;
  int sent_count = 0;

  // Surrogate pair for U+10FFFF with a few errors around it
  logic [7:0] directed_text [0:24] = '{
    8'h00, 8'h20, 8'h0D, 8'h22, 8'hFF, 8'h7F, 8'h5C, 8'h2F, 8'h22,
    8'h22, 8'h5C, 8'h75, 8'h44, 8'h42, 8'h46, 8'h46,
    8'h5C, 8'h75, 8'h64, 8'h66, 8'h66, 8'h66,
    8'h1F, 8'h22, 8'h00
  };

  logic [7:0] simple_escapes [0:7] = '{
    8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74
  };

  json_string_unescape_utf8_top u_top (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .in_byte    (in_byte),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .kind       (kind),
    .error_code (error_code),
    .last       (last)
  );

  jsu_utf8_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .in_byte    (in_byte),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .kind       (kind),
    .error_code (error_code),
    .last       (last),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Pop side: stall at random while pop_level is set
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      pop_wait <= 0;
    end else if (pop_wait > 0) begin
      pop <= 1'b0;
      pop_wait <= pop_wait - 1;
    end else begin
      pop <= 1'b1;
      if (pop_level != 0 && $urandom_range(0, 2) == 0) pop_wait <= pick_gap();
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_run <= 0;
    else idle_run <= idle_run + 1;
    if (idle_run >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Present one byte and hold it until it is taken
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (send_level != 0 && $urandom_range(0, 3) == 0) gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    sent_count++;
  endtask

  // Hold off until every expected word has been popped
  task automatic wait_drain();
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    if ($urandom_range(0, 1) == 0) return 8'h61 + (n - 4'd10);
    return 8'h41 + (n - 4'd10);
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
           (b >= 8'h41 && b <= 8'h46));
    return b;
  endfunction

  function automatic logic [7:0] bad_escape_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b == 8'h22 || b == 8'h5C || b == 8'h2F || b == 8'h62 || b == 8'h66 ||
           b == 8'h6E || b == 8'h72 || b == 8'h74 || b == CH_U);
    return b;
  endfunction

  task automatic send_unicode(input logic [15:0] v);
    send_byte(CH_BSLASH);
    send_byte(CH_U);
    for (int i = 3; i >= 0; i--) send_byte(hex_char(v[i*4 +: 4]));
  endtask

  function automatic logic [15:0] high_half();
    return 16'hD800 + 16'($urandom_range(0, 16'h3FF));
  endfunction

  function automatic logic [15:0] low_half();
    return 16'hDC00 + 16'($urandom_range(0, 16'h3FF));
  endfunction

  // One well-formed piece of string content
  task automatic send_element();
    logic [7:0]  b;
    logic [15:0] v;
    case ($urandom_range(0, 5))
      0, 1: begin
        b = 8'($urandom_range(8'h20, 8'hFF));
        if (b == CH_QUOTE || b == CH_BSLASH) b = b ^ 8'h01;
        send_byte(b);
      end
      2: begin
        send_byte(CH_BSLASH);
        send_byte(simple_escapes[$urandom_range(0, 7)]);
      end
      3: begin
        case ($urandom_range(0, 2))
          0: v = 16'($urandom_range(0, 16'h7F));
          1: v = 16'($urandom_range(16'h80, 16'h7FF));
          default: v = 16'($urandom_range(16'h800, 16'hFFFF));
        endcase
        if (v >= 16'hD800 && v <= 16'hDFFF) v = v ^ 16'h2000;
        send_unicode(v);
      end
      4: begin
        send_unicode(high_half());
        send_unicode(low_half());
      end
      default: send_unicode(low_half());
    endcase
  endtask

  // Finish the string with one of the error conditions
  task automatic send_broken();
    logic [7:0]  b;
    logic [15:0] v;
    int          k;
    case ($urandom_range(0, 8))
      0: send_byte(8'h00);
      1: send_byte(8'($urandom_range(1, 8'h1F)));
      2: begin
        send_byte(CH_BSLASH);
        send_byte(8'h00);
      end
      3: begin
        send_byte(CH_BSLASH);
        send_byte(bad_escape_byte());
      end
      4: begin
        send_byte(CH_BSLASH);
        send_byte(CH_U);
        k = $urandom_range(0, 3);
        for (int i = 0; i < k; i++) send_byte(hex_char(4'($urandom_range(0, 15))));
        send_byte(8'h00);
      end
      5: begin
        // Bad digit, in the first escape or in the second of a pair
        if ($urandom_range(0, 1) == 0) begin
          send_unicode(high_half());
        end
        send_byte(CH_BSLASH);
        send_byte(CH_U);
        k = $urandom_range(0, 3);
        for (int i = 0; i < 4; i++) begin
          if (i == k) send_byte(non_hex_byte());
          else send_byte(hex_char(4'($urandom_range(0, 15))));
        end
      end
      6: begin
        send_unicode(high_half());
        do b = 8'($urandom_range(0, 255)); while (b == CH_BSLASH);
        send_byte(b);
      end
      7: begin
        send_unicode(high_half());
        send_byte(CH_BSLASH);
        do b = 8'($urandom_range(0, 255)); while (b == CH_U);
        send_byte(b);
      end
      default: begin
        send_unicode(high_half());
        v = 16'($urandom_range(0, 16'hFFFF));
        if (v >= 16'hDC00 && v <= 16'hDFFF) v = v ^ 16'h4000;
        send_unicode(v);
      end
    endcase
  endtask

  task automatic send_random_string();
    logic [7:0] b;
    int         n;
    n = $urandom_range(0, 2);
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(0, 5));
      send_byte(b == 8'd5 ? 8'h20 : 8'h09 + b);
    end
    // Occasional stray byte between strings
    if ($urandom_range(0, 19) == 0) begin
      send_byte(8'($urandom_range(0, 255)));
    end else begin
      send_byte(CH_QUOTE);
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) send_element();
      if ($urandom_range(0, 9) < 7) send_byte(CH_QUOTE);
      else send_broken();
    end
  endtask

  initial begin
    int phase_end;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_text[i]) send_byte(directed_text[i]);
    wait_drain();

    // Sweep idling: none, sender only, receiver only, both
    for (int p = 0; p < 4; p++) begin
      send_level = p % 2;
      pop_level = p / 2;
      phase_end = sent_count + PHASE_BYTES;
      while (sent_count < phase_end) send_random_string();
      wait_drain();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
